// ===== rtl/vcf_pkg.sv =====
// Shared types, register codes and constants of the voice capture front end.
`timescale 1ns / 1ps
package vcf_pkg;

	// Field and register widths.
	localparam int SAMPLE_W    = 16;
	localparam int SUM_W       = 20;
	localparam int CNT_W       = 4;
	localparam int FMT_W       = 2;
	localparam int STEP_W      = 28;
	localparam int GAIN_W      = 17;
	localparam int PEAK_W      = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 28;

	// Reciprocal table for the channel average: q = (n * RECIP[d]) >> RECIP_SHIFT.
	localparam int RECIP_W     = 26;
	localparam int RECIP_SHIFT = 25;

	// Gain is unsigned Q3.14.
	localparam int GAIN_SHIFT  = 14;
	localparam logic [GAIN_W-1:0] GAIN_MAX = 17'd65536;

	// Depth of the command queue between front and back.
	localparam int CMD_DEPTH   = 4;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FORMAT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_RATIO    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIC_GAIN      = 2'd3;

	// Sample format codes.
	localparam logic [FMT_W-1:0] FMT_FLOAT32 = 2'd0;
	localparam logic [FMT_W-1:0] FMT_PCM16   = 2'd1;
	localparam logic [FMT_W-1:0] FMT_PCM32   = 2'd2;
	localparam logic [FMT_W-1:0] FMT_NONE    = 2'd3;

	// Register values after reset.
	localparam logic [CNT_W-1:0]  RST_CHANNEL_COUNT = 4'd2;
	localparam logic [FMT_W-1:0]  RST_SAMPLE_FORMAT = FMT_FLOAT32;
	localparam logic [STEP_W-1:0] RST_STEP_RATIO    = 28'd16777216;
	localparam logic [GAIN_W-1:0] RST_MIC_GAIN      = 17'd16384;

	typedef struct packed {
		logic [31:0] sample_word;
		logic        silent;
		logic        transmit;
	} item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] out_sample;
		logic                       last_of_frame;
		logic [PEAK_W-1:0]          frame_peak;
		logic                       frame_abort;
		logic                       last_of_run;
	} result_t;

	typedef struct packed {
		logic [CNT_W-1:0]  channel_count;
		logic [FMT_W-1:0]  sample_format;
		logic [STEP_W-1:0] step_ratio;
		logic [GAIN_W-1:0] mic_gain;
	} cfg_t;

	// One classified word handed from the front to the back.
	typedef struct packed {
		logic                    transmit;
		logic                    done;
		logic signed [SUM_W-1:0] sum;
		logic [CNT_W-1:0]        count;
	} cmd_t;

	// Ceiling of 2^RECIP_SHIFT / d; exact for every sum magnitude below 2^SUM_W.
	function automatic logic [RECIP_W-1:0] recip_lut(input logic [CNT_W-1:0] d);
		logic [RECIP_W-1:0] r;
		case (d)
			4'd2:    r = 26'd16777216;
			4'd3:    r = 26'd11184811;
			4'd4:    r = 26'd8388608;
			4'd5:    r = 26'd6710887;
			4'd6:    r = 26'd5592406;
			4'd7:    r = 26'd4793491;
			4'd8:    r = 26'd4194304;
			4'd9:    r = 26'd3728271;
			4'd10:   r = 26'd3355444;
			4'd11:   r = 26'd3050403;
			4'd12:   r = 26'd2796203;
			4'd13:   r = 26'd2581111;
			4'd14:   r = 26'd2396746;
			4'd15:   r = 26'd2236963;
			default: r = 26'd33554432;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/voice_capture_frontend_core.sv =====
// Top level of the voice capture front end: configuration registers and the front/back split.
//
// Channel   Ports                                      Word moves when
// item      push, full, item                           push && !full
// result    empty, pop, result                         pop && !empty
// config    cfg_valid, cfg_ready, cfg_index, cfg_data  cfg_valid && cfg_ready
//
// In a two-stage pipeline the front converts one word per cycle and queues it for the back
// while the queue has room. The back takes each word from the queue in its idle state; a
// word that closes a source frame goes through an averaging and a gain state and emits up
// to eight output samples, after an abort marker if one is sent.
// Reset clears all frame, phase and channel state and loads the register defaults.
// A held result stalls the back; the queue of four words lets the front keep accepting
// until it fills, and then full rises.
`timescale 1ns / 1ps
module voice_capture_frontend_core #(
	parameter int MAX_CHANNELS    = 8,
	parameter int FRAME_SAMPLES   = 960,
	parameter int PHASE_FRAC_BITS = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  vcf_pkg::item_t                    item,
	output logic                              full,
	output logic                              empty,
	input  logic                              pop,
	output vcf_pkg::result_t                  result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [vcf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [vcf_pkg::CFG_DATA_W-1:0]    cfg_data
);

	vcf_pkg::cfg_t cfg_q;
	vcf_pkg::cmd_t front_cmd;
	vcf_pkg::cmd_t back_cmd;
	logic          cmd_push;
	logic          cmd_full;
	logic          cmd_pop;
	logic          cmd_empty;

	assign cfg_ready = 1'b1;

	// Configuration register file.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.channel_count <= vcf_pkg::RST_CHANNEL_COUNT;
			cfg_q.sample_format <= vcf_pkg::RST_SAMPLE_FORMAT;
			cfg_q.step_ratio    <= vcf_pkg::RST_STEP_RATIO;
			cfg_q.mic_gain      <= vcf_pkg::RST_MIC_GAIN;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				vcf_pkg::REG_CHANNEL_COUNT:
					cfg_q.channel_count <= cfg_data[vcf_pkg::CNT_W-1:0];
				vcf_pkg::REG_SAMPLE_FORMAT:
					cfg_q.sample_format <= cfg_data[vcf_pkg::FMT_W-1:0];
				vcf_pkg::REG_STEP_RATIO:
					cfg_q.step_ratio    <= cfg_data[vcf_pkg::STEP_W-1:0];
				vcf_pkg::REG_MIC_GAIN:
					cfg_q.mic_gain      <= cfg_data[vcf_pkg::GAIN_W-1:0];
			endcase
		end
	end

	vcf_front #(
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.push     (push),
		.item     (item),
		.full     (full),
		.cmd      (front_cmd),
		.cmd_push (cmd_push),
		.cmd_full (cmd_full)
	);

	vcf_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (cmd_push),
		.wr_data (front_cmd),
		.full    (cmd_full),
		.pop     (cmd_pop),
		.rd_data (back_cmd),
		.empty   (cmd_empty)
	);

	vcf_back #(
		.FRAME_SAMPLES  (FRAME_SAMPLES),
		.PHASE_FRAC_BITS(PHASE_FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd       (back_cmd),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

// ===== rtl/vcf_front.sv =====
// Front part: accepts channel words, converts them and sums the channels of a source frame.
`timescale 1ns / 1ps
module vcf_front #(
	parameter int MAX_CHANNELS = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  vcf_pkg::cfg_t  cfg,
	input  logic           push,
	input  vcf_pkg::item_t item,
	output logic           full,
	output vcf_pkg::cmd_t  cmd,
	output logic           cmd_push,
	input  logic           cmd_full
);

	localparam int IDX_W = $clog2(MAX_CHANNELS + 1);
	localparam int CMP_W = (IDX_W > vcf_pkg::CNT_W) ? IDX_W : vcf_pkg::CNT_W;

	// Converts one raw word to a signed 16-bit sample.
	function automatic logic signed [15:0] to_sample(input logic [31:0] w,
			input logic [vcf_pkg::FMT_W-1:0] fmt);
		logic        neg;
		logic [7:0]  e;
		logic [23:0] m;
		logic [38:0] p;
		logic [7:0]  sh;
		logic [16:0] mag;
		logic signed [15:0] r;
		neg = w[31];
		e   = w[30:23];
		m   = {1'b1, w[22:0]};
		// Mantissa times 32767 as a shift and a subtract.
		p   = {m, 15'b0} - {15'b0, m};
		sh  = 8'd150 - e;
		mag = '0;
		r   = '0;
		unique case (fmt)
			vcf_pkg::FMT_FLOAT32: begin
				if (e == 8'hFF) begin
					if (w[22:0] != 23'd0) begin
						r = '0;
					end else begin
						r = neg ? 16'sh8000 : 16'sh7FFF;
					end
				end else if (e == 8'h00) begin
					r = '0;
				end else if (e >= 8'd128) begin
					r = neg ? 16'sh8000 : 16'sh7FFF;
				end else begin
					mag = (sh >= 8'd39) ? 17'd0 : 17'(p >> sh);
					if (neg) begin
						r = (mag > 17'd32768) ? 16'sh8000 : 16'(17'd0 - mag);
					end else begin
						r = (mag > 17'd32767) ? 16'sh7FFF : mag[15:0];
					end
				end
			end
			vcf_pkg::FMT_PCM16: r = w[15:0];
			vcf_pkg::FMT_PCM32: r = w[31:16];
			vcf_pkg::FMT_NONE:  r = '0;
		endcase
		return r;
	endfunction

	logic                           valid_s1;
	vcf_pkg::item_t                 item_s1;
	logic                           valid_s2;
	logic signed [15:0]             sample_s2;
	logic                           transmit_s2;
	logic [IDX_W-1:0]               idx_q;
	logic signed [vcf_pkg::SUM_W-1:0] sum_q;

	logic                           adv2;
	logic                           adv1;
	logic [vcf_pkg::CNT_W-1:0]      count_eff;
	logic [IDX_W-1:0]               idx_next;
	logic signed [vcf_pkg::SUM_W-1:0] sum_next;
	logic                           frame_done;

	// Stage handshake: a stage moves when the one after it has room.
	assign adv2     = !valid_s2 || !cmd_full;
	assign adv1     = !valid_s1 || adv2;
	assign full     = !adv1;
	assign cmd_push = valid_s2 && !cmd_full;

	// Channel count with out-of-range values folded into the legal range.
	always_comb begin
		if (cfg.channel_count == '0) begin
			count_eff = vcf_pkg::CNT_W'(1);
		end else if (int'(cfg.channel_count) > MAX_CHANNELS) begin
			count_eff = vcf_pkg::CNT_W'(MAX_CHANNELS);
		end else begin
			count_eff = cfg.channel_count;
		end
	end

	// Channel accumulation; the word that reaches the count closes the source frame.
	assign idx_next   = idx_q + IDX_W'(1);
	assign sum_next   = sum_q + {{(vcf_pkg::SUM_W - 16){sample_s2[15]}}, sample_s2};
	assign frame_done = CMP_W'(idx_next) >= CMP_W'(count_eff);

	assign cmd.transmit = transmit_s2;
	assign cmd.done     = frame_done;
	assign cmd.sum      = sum_next;
	assign cmd.count    = count_eff;

	// Pipeline valid bits and accumulator state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			idx_q    <= '0;
			sum_q    <= '0;
		end else begin
			if (adv1) begin
				valid_s1 <= push;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
			if (cmd_push) begin
				if (frame_done) begin
					idx_q <= '0;
					sum_q <= '0;
				end else begin
					idx_q <= idx_next;
					sum_q <= sum_next;
				end
			end
		end
	end

	// Pipeline payload.
	always_ff @(posedge clk) begin
		if (adv1 && push) begin
			item_s1 <= item;
		end
		if (adv2 && valid_s1) begin
			sample_s2   <= item_s1.silent ? 16'sd0 :
				to_sample(item_s1.sample_word, cfg.sample_format);
			transmit_s2 <= item_s1.transmit;
		end
	end

endmodule

// ===== rtl/vcf_fifo.sv =====
// Short command queue between the front and the back part.
`timescale 1ns / 1ps
module vcf_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  vcf_pkg::cmd_t wr_data,
	output logic          full,
	input  logic          pop,
	output vcf_pkg::cmd_t rd_data,
	output logic          empty
);

	localparam int PTR_W = $clog2(vcf_pkg::CMD_DEPTH);
	localparam int CNT_W = $clog2(vcf_pkg::CMD_DEPTH + 1);

	vcf_pkg::cmd_t    mem_q [vcf_pkg::CMD_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = cnt_q == CNT_W'(vcf_pkg::CMD_DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(vcf_pkg::CMD_DEPTH - 1)) ? '0 :
					wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(vcf_pkg::CMD_DEPTH - 1)) ? '0 :
					rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ===== rtl/vcf_back.sv =====
// Back part: averages, resamples, applies gain and frames the output samples.
`timescale 1ns / 1ps
module vcf_back #(
	parameter int FRAME_SAMPLES   = 960,
	parameter int PHASE_FRAC_BITS = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  vcf_pkg::cfg_t    cfg,
	input  vcf_pkg::cmd_t    cmd,
	input  logic             cmd_empty,
	output logic             cmd_pop,
	output vcf_pkg::result_t result,
	output logic             empty,
	input  logic             pop
);

	localparam int PH_W   = ((PHASE_FRAC_BITS > 27) ? PHASE_FRAC_BITS : 27) + 2;
	localparam int FILL_W = $clog2(FRAME_SAMPLES + 1);
	localparam int PROD_W = vcf_pkg::SUM_W + vcf_pkg::RECIP_W;
	localparam int GP_W   = 36;
	localparam logic [PH_W-1:0] PH_ONE      = {{(PH_W - 1){1'b0}}, 1'b1} << PHASE_FRAC_BITS;
	localparam logic [PH_W-1:0] PH_MIN_STEP = PH_ONE >> 3;

	typedef enum logic [4:0] {
		B_IDLE  = 5'b00001,
		B_ABORT = 5'b00010,
		B_DIV   = 5'b00100,
		B_GAIN  = 5'b01000,
		B_EMIT  = 5'b10000
	} bstate_t;

	bstate_t                 state_q;
	vcf_pkg::cmd_t           cmd_q;
	logic [PROD_W-1:0]       div_prod_q;
	logic signed [GP_W-1:0]  gain_prod_q;
	logic [PH_W-1:0]         phase_q;
	logic [FILL_W-1:0]       fill_q;
	logic [vcf_pkg::PEAK_W-1:0] peak_q;
	logic                    res_valid_q;
	vcf_pkg::result_t        res_q;

	logic [PH_W-1:0]         step_eff;
	logic [PH_W-1:0]         phase_nxt;
	logic                    wrap;
	logic                    phase_done;
	logic [vcf_pkg::GAIN_W-1:0] gain_eff;
	logic [vcf_pkg::SUM_W-1:0]  sum_mag;
	logic [16:0]             quot;
	logic signed [17:0]      mono;
	logic signed [GP_W-1:0]  biased;
	logic signed [GP_W-1:0]  scaled;
	logic signed [15:0]      sample_v;
	logic signed [16:0]      sample_ext;
	logic [16:0]             sample_abs;
	logic [vcf_pkg::PEAK_W-1:0] peak_max;
	logic [FILL_W-1:0]       fill_inc;
	logic                    frame_end;
	logic                    slot_free;
	logic                    emit_fire;
	logic                    abort_fire;
	logic                    emit_adv;
	vcf_pkg::result_t        res_next;

	// Phase step, clamped so that a source frame yields at most eight samples.
	always_comb begin
		if (PH_W'(cfg.step_ratio) < PH_MIN_STEP) begin
			step_eff = PH_MIN_STEP;
		end else begin
			step_eff = PH_W'(cfg.step_ratio);
		end
	end
	assign phase_nxt  = phase_q + step_eff;
	assign wrap       = phase_nxt >= PH_ONE;
	assign phase_done = phase_q >= PH_ONE;

	assign gain_eff = (cfg.mic_gain > vcf_pkg::GAIN_MAX) ? vcf_pkg::GAIN_MAX : cfg.mic_gain;

	// Channel average by reciprocal multiply, truncated toward zero.
	assign sum_mag = cmd_q.sum[vcf_pkg::SUM_W-1] ? vcf_pkg::SUM_W'(-cmd_q.sum) :
		vcf_pkg::SUM_W'(cmd_q.sum);
	assign quot = div_prod_q[vcf_pkg::RECIP_SHIFT +: 17];
	assign mono = cmd_q.sum[vcf_pkg::SUM_W-1] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

	// Gain scaling: divide by 2^14 toward zero, then clip to 16 bits.
	always_comb begin
		biased = gain_prod_q + (gain_prod_q[GP_W-1] ? GP_W'(16383) : GP_W'(0));
		scaled = biased >>> vcf_pkg::GAIN_SHIFT;
		if (scaled > GP_W'(32767)) begin
			sample_v = 16'sh7FFF;
		end else if (scaled < -GP_W'(32768)) begin
			sample_v = 16'sh8000;
		end else begin
			sample_v = scaled[15:0];
		end
	end
	assign sample_ext = {sample_v[15], sample_v};
	assign sample_abs = sample_ext[16] ? 17'(-sample_ext) : 17'(sample_ext);
	assign peak_max   = (sample_abs[15:0] > peak_q) ? sample_abs[15:0] : peak_q;
	assign fill_inc   = fill_q + FILL_W'(1);
	assign frame_end  = fill_inc >= FILL_W'(FRAME_SAMPLES);

	// Output slot handshake.
	assign slot_free  = !res_valid_q || pop;
	assign emit_fire  = (state_q == B_EMIT) && !phase_done && cmd_q.transmit && slot_free;
	assign abort_fire = (state_q == B_ABORT) && slot_free;
	assign emit_adv   = !cmd_q.transmit || slot_free;
	assign cmd_pop    = (state_q == B_IDLE) && !cmd_empty;
	assign empty      = !res_valid_q;
	assign result     = res_q;

	// Result word for the abort marker or for a sample.
	always_comb begin
		if (state_q == B_ABORT) begin
			res_next.out_sample    = '0;
			res_next.last_of_frame = 1'b0;
			res_next.frame_peak    = '0;
			res_next.frame_abort   = 1'b1;
			res_next.last_of_run   = 1'b1;
		end else begin
			res_next.out_sample    = sample_v;
			res_next.last_of_frame = frame_end;
			res_next.frame_peak    = frame_end ? peak_max : '0;
			res_next.frame_abort   = 1'b0;
			res_next.last_of_run   = wrap;
		end
	end

	// Sequencer, phase accumulator and frame state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			phase_q     <= '0;
			fill_q      <= '0;
			peak_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (emit_fire || abort_fire) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end

			unique case (state_q)
				B_IDLE: begin
					if (!cmd_empty) begin
						if (!cmd.transmit) begin
							fill_q <= '0;
							peak_q <= '0;
						end
						if (!cmd.transmit && (fill_q != '0)) begin
							state_q <= B_ABORT;
						end else if (cmd.done) begin
							state_q <= B_DIV;
						end
					end
				end
				B_ABORT: begin
					if (slot_free) begin
						state_q <= cmd_q.done ? B_DIV : B_IDLE;
					end
				end
				B_DIV: begin
					state_q <= B_GAIN;
				end
				B_GAIN: begin
					state_q <= B_EMIT;
				end
				B_EMIT: begin
					if (phase_done) begin
						phase_q <= phase_q - PH_ONE;
						state_q <= B_IDLE;
					end else if (emit_adv) begin
						phase_q <= wrap ? (phase_nxt - PH_ONE) : phase_nxt;
						if (wrap) begin
							state_q <= B_IDLE;
						end
					end
					if (emit_fire) begin
						if (frame_end) begin
							fill_q <= '0;
							peak_q <= '0;
						end else begin
							fill_q <= fill_inc;
							peak_q <= peak_max;
						end
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
		if (state_q == B_DIV) begin
			div_prod_q <= PROD_W'(sum_mag) * PROD_W'(vcf_pkg::recip_lut(cmd_q.count));
		end
		if (state_q == B_GAIN) begin
			gain_prod_q <= GP_W'(mono) * GP_W'($signed({1'b0, gain_eff}));
		end
		if (emit_fire || abort_fire) begin
			res_q <= res_next;
		end
	end

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the voice capture front end with a predictor.
`timescale 1ns / 1ps
module tb_top;

	localparam int FRAME_LEN     = 960;
	localparam int MAX_CH        = 8;
	localparam int FRAC_BITS     = 24;
	localparam int SETTLE_CYCLES = 128;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int PRINT_CAP     = 20;
	localparam int IDX_W         = vcf_pkg::CFG_IDX_W;
	localparam int DATA_W        = vcf_pkg::CFG_DATA_W;

	logic clk;
	logic arst_n;
	logic push;
	vcf_pkg::item_t item;
	logic full;
	logic empty;
	logic pop;
	vcf_pkg::result_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0] cfg_data;

	voice_capture_frontend_core #(
		.MAX_CHANNELS(MAX_CH),
		.FRAME_SAMPLES(FRAME_LEN),
		.PHASE_FRAC_BITS(FRAC_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.item(item),
		.full(full),
		.empty(empty),
		.pop(pop),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Words waiting for the driver and output words the predictor says are due.
	vcf_pkg::item_t words_to_send[$];
	vcf_pkg::result_t mono_outputs_due[$];

	// Predictor copy of the registers.
	logic [vcf_pkg::CNT_W-1:0] chan_count_reg;
	logic [vcf_pkg::FMT_W-1:0] format_reg;
	logic [vcf_pkg::STEP_W-1:0] step_reg;
	logic [vcf_pkg::GAIN_W-1:0] gain_reg;

	// Predictor copy of the capture state.
	int chan_idx;
	int chan_sum;
	longint unsigned phase_acc;
	int frame_fill;
	int peak_abs;

	bit item_taken;
	bit calm;
	int fail_count;
	int cycle_count;
	int words_sent;
	int outputs_seen;
	int frames_seen;
	int aborts_seen;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d words still due.", cycle_count,
				mono_outputs_due.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		fail_count++;
		if (fail_count <= PRINT_CAP)
			$display("%0t: mismatch: %s", $time, what);
	endtask

	function automatic int sat16(input longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return int'(v);
	endfunction

	// Float32 scaled by 32767, truncated toward zero and clipped.
	function automatic int float_to_s16(input logic [31:0] w);
		int ex;
		int sh;
		longint unsigned mant;
		longint unsigned mag;
		ex = int'(w[30:23]);
		mant = 64'(w[22:0]);
		if (ex == 255) return (mant != 0) ? 0 : (w[31] ? -32768 : 32767);
		if (ex == 0) return 0;
		if (ex >= 128) begin
			mag = 65536;
		end else begin
			sh = 150 - ex;
			mant = mant | 64'h800000;
			mag = (sh >= 64) ? 0 : ((mant * 32767) >> sh);
		end
		return sat16(w[31] ? -longint'(mag) : longint'(mag));
	endfunction

	function automatic int word_to_s16(input logic [31:0] w);
		case (format_reg)
			vcf_pkg::FMT_FLOAT32: return float_to_s16(w);
			vcf_pkg::FMT_PCM16:   return int'($signed(w[15:0]));
			vcf_pkg::FMT_PCM32:   return int'($signed(w[31:16]));
			default:              return 0;
		endcase
	endfunction

	// Works out the output words caused by one accepted channel word.
	task automatic predict_capture(input vcf_pkg::item_t it);
		int count;
		int mono;
		int v;
		int a;
		int g;
		longint unsigned one_frame;
		longint unsigned step;
		vcf_pkg::result_t r;
		vcf_pkg::result_t batch[$];
		count = int'(chan_count_reg);
		if (count == 0) count = 1;
		if (count > MAX_CH) count = MAX_CH;
		// Push-to-talk released: abort any partial frame.
		if (!it.transmit) begin
			if (frame_fill != 0) begin
				r = '0;
				r.frame_abort = 1'b1;
				batch.insert(batch.size(), r);
			end
			frame_fill = 0;
			peak_abs = 0;
		end
		chan_sum += it.silent ? 0 : word_to_s16(it.sample_word);
		chan_idx++;
		// A completed source frame is averaged and resampled.
		if (chan_idx >= count) begin
			mono = chan_sum / count;
			chan_sum = 0;
			chan_idx = 0;
			one_frame = longint'(1) << FRAC_BITS;
			step = 64'(step_reg);
			if (step < (one_frame >> 3)) step = one_frame >> 3;
			g = (gain_reg > vcf_pkg::GAIN_MAX) ? int'(vcf_pkg::GAIN_MAX) : int'(gain_reg);
			while (phase_acc < one_frame) begin
				phase_acc += step;
				if (it.transmit && batch.size() < 8) begin
					v = sat16((longint'(mono) * g) / 16384);
					a = (v < 0) ? -v : v;
					if (a > peak_abs) peak_abs = a;
					frame_fill++;
					r = '0;
					r.out_sample = v[15:0];
					if (frame_fill >= FRAME_LEN) begin
						r.last_of_frame = 1'b1;
						r.frame_peak = peak_abs[15:0];
						frame_fill = 0;
						peak_abs = 0;
					end
					batch.insert(batch.size(), r);
				end
			end
			phase_acc -= one_frame;
		end
		if (batch.size() > 0) batch[batch.size() - 1].last_of_run = 1'b1;
		foreach (batch[k]) mono_outputs_due.insert(mono_outputs_due.size(), batch[k]);
	endtask

	// Monitor: predicts on accepted input words and checks accepted output words.
	always @(posedge clk) begin
		vcf_pkg::result_t want;
		item_taken = arst_n && push && !full;
		if (item_taken) begin
			words_sent++;
			predict_capture(item);
		end
		if (arst_n && pop && !empty) begin
			outputs_seen++;
			if (result.last_of_frame) frames_seen++;
			if (result.frame_abort) aborts_seen++;
			if (mono_outputs_due.size() == 0) begin
				report_mismatch($sformatf("output word with nothing due, sample %0d",
					result.out_sample));
			end else begin
				want = mono_outputs_due.pop_front();
				if (result.out_sample !== want.out_sample)
					report_mismatch($sformatf("out_sample %0d, predicted %0d",
						result.out_sample, want.out_sample));
				if (result.last_of_frame !== want.last_of_frame)
					report_mismatch($sformatf("last_of_frame %b, predicted %b",
						result.last_of_frame, want.last_of_frame));
				if (result.frame_peak !== want.frame_peak)
					report_mismatch($sformatf("frame_peak %0d, predicted %0d",
						result.frame_peak, want.frame_peak));
				if (result.frame_abort !== want.frame_abort)
					report_mismatch($sformatf("frame_abort %b, predicted %b",
						result.frame_abort, want.frame_abort));
				if (result.last_of_run !== want.last_of_run)
					report_mismatch($sformatf("last_of_run %b, predicted %b",
						result.last_of_run, want.last_of_run));
			end
		end
	end

	// Driver: presents queued words, idling now and then unless the stretch is calm.
	always @(negedge clk) begin
		if (arst_n && (!push || item_taken)) begin
			if (words_to_send.size() != 0 && (calm || $urandom_range(99) >= 9)) begin
				item <= words_to_send.pop_front();
				push <= 1'b1;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// Output side stalls at random too.
	always @(negedge clk) begin
		if (arst_n) pop <= calm || ($urandom_range(99) >= 9);
	end

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			vcf_pkg::REG_CHANNEL_COUNT: chan_count_reg = data[vcf_pkg::CNT_W-1:0];
			vcf_pkg::REG_SAMPLE_FORMAT: format_reg = data[vcf_pkg::FMT_W-1:0];
			vcf_pkg::REG_STEP_RATIO:    step_reg = data[vcf_pkg::STEP_W-1:0];
			vcf_pkg::REG_MIC_GAIN:      gain_reg = data[vcf_pkg::GAIN_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Waits until every word is sent and every output word has arrived, then lets the back settle.
	task automatic wait_idle();
		while (words_to_send.size() != 0 || push || mono_outputs_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic queue_word(input logic [31:0] w, input logic s, input logic tx);
		vcf_pkg::item_t it;
		it.sample_word = w;
		it.silent = s;
		it.transmit = tx;
		words_to_send.insert(words_to_send.size(), it);
	endtask

	// Random raw word shaped for the current format.
	function automatic logic [31:0] random_word();
		int pick;
		pick = $urandom_range(99);
		if (format_reg == vcf_pkg::FMT_FLOAT32) begin
			if (pick < 75)
				return {1'($urandom_range(1)), 8'($urandom_range(127, 100)),
					23'($urandom)};
			if (pick < 85)
				return {1'($urandom_range(1)), 8'($urandom_range(140, 127)),
					23'($urandom)};
			return $urandom;
		end
		if (format_reg == vcf_pkg::FMT_PCM16 && pick < 10)
			return {16'($urandom), pick[0] ? 16'h7FFF : 16'h8000};
		return $urandom;
	endfunction

	// One setting of all registers followed by random words.
	task automatic run_phase(input int cnt, input int fmt, input int step, input int gain,
		input int n, input int tx_low_pct, input bit quiet);
		write_reg(vcf_pkg::REG_CHANNEL_COUNT, DATA_W'(cnt));
		write_reg(vcf_pkg::REG_SAMPLE_FORMAT, DATA_W'(fmt));
		write_reg(vcf_pkg::REG_STEP_RATIO, DATA_W'(step));
		write_reg(vcf_pkg::REG_MIC_GAIN, DATA_W'(gain));
		calm = quiet;
		for (int i = 0; i < n; i++) begin
			// In quiet phases the sender holds off halfway until everything has drained.
			if (quiet && i == n / 2) wait_idle();
			queue_word(random_word(), $urandom_range(99) < 8,
				$urandom_range(99) >= tx_low_pct);
		end
		wait_idle();
		calm = 1'b0;
	endtask

	initial begin
		push = 1'b0;
		pop = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		calm = 1'b0;
		chan_count_reg = vcf_pkg::RST_CHANNEL_COUNT;
		format_reg = vcf_pkg::RST_SAMPLE_FORMAT;
		step_reg = vcf_pkg::RST_STEP_RATIO;
		gain_reg = vcf_pkg::RST_MIC_GAIN;
		chan_idx = 0;
		chan_sum = 0;
		phase_acc = 0;
		frame_fill = 0;
		peak_abs = 0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Float extremes in pairs at the reset setting of two channels.
		queue_word(32'h3F800000, 1'b0, 1'b1);
		queue_word(32'hBF800000, 1'b0, 1'b1);
		queue_word(32'h7F800000, 1'b0, 1'b1);
		queue_word(32'hFF800000, 1'b0, 1'b1);
		queue_word(32'h7FC00000, 1'b0, 1'b1);
		queue_word(32'h00000001, 1'b0, 1'b1);
		queue_word(32'h47000000, 1'b0, 1'b1);
		queue_word(32'h00000000, 1'b0, 1'b1);
		queue_word(32'h3F800000, 1'b1, 1'b1);
		queue_word(32'h3F000000, 1'b0, 1'b1);
		queue_word(32'hFFFFFFFF, 1'b0, 1'b1);
		queue_word(32'h80000000, 1'b0, 1'b1);
		// Release push-to-talk with a partial frame pending, then again with none.
		queue_word(32'h3F800000, 1'b0, 1'b0);
		queue_word(32'h3F800000, 1'b0, 1'b0);
		wait_idle();

		// Integer formats at their extremes, with junk in the unused bits.
		write_reg(vcf_pkg::REG_SAMPLE_FORMAT, DATA_W'(vcf_pkg::FMT_PCM16));
		queue_word(32'h00007FFF, 1'b0, 1'b1);
		queue_word(32'h00008000, 1'b0, 1'b1);
		queue_word(32'hFFFF7FFF, 1'b0, 1'b1);
		queue_word(32'hFFFF8000, 1'b0, 1'b1);
		wait_idle();
		write_reg(vcf_pkg::REG_SAMPLE_FORMAT, DATA_W'(vcf_pkg::FMT_PCM32));
		queue_word(32'h7FFFFFFF, 1'b0, 1'b1);
		queue_word(32'h80000000, 1'b0, 1'b1);
		wait_idle();
		write_reg(vcf_pkg::REG_SAMPLE_FORMAT, DATA_W'(vcf_pkg::FMT_NONE));
		queue_word(32'h12345678, 1'b0, 1'b1);
		queue_word(32'hFFFFFFFF, 1'b0, 1'b1);
		wait_idle();

		// Channel count lowered mid frame: the next word closes the frame.
		write_reg(vcf_pkg::REG_SAMPLE_FORMAT, DATA_W'(vcf_pkg::FMT_PCM16));
		write_reg(vcf_pkg::REG_CHANNEL_COUNT, DATA_W'(4));
		queue_word(32'd1000, 1'b0, 1'b1);
		queue_word(32'd2000, 1'b0, 1'b1);
		queue_word(32'd3000, 1'b0, 1'b1);
		wait_idle();
		write_reg(vcf_pkg::REG_CHANNEL_COUNT, DATA_W'(2));
		queue_word(32'd4000, 1'b0, 1'b1);
		wait_idle();

		// Random phases, extremes of every register first.
		run_phase(2, int'(vcf_pkg::FMT_FLOAT32), 16777216, 16384, 70, 3, 1'b0);
		run_phase(1, int'(vcf_pkg::FMT_PCM16), 0, 65536, 130, 0, 1'b1);
		run_phase(15, int'(vcf_pkg::FMT_PCM32), 268435455, 131071, 60, 3, 1'b0);
		run_phase(3, int'(vcf_pkg::FMT_NONE), 2097152, 0, 30, 5, 1'b0);
		run_phase(0, int'(vcf_pkg::FMT_FLOAT32), 12582912, 8192, 60, 3, 1'b0);
		for (int p = 0; p < 3; p++)
			run_phase($urandom_range(MAX_CH, 1), $urandom_range(2), $urandom_range(134217728,
				2097152), $urandom_range(65536), 35, 3, 1'b0);

		wait_idle();
		if (mono_outputs_due.size() != 0)
			report_mismatch($sformatf("%0d predicted words never arrived",
				mono_outputs_due.size()));
		$display("Run covered %0d channel words and %0d output words over all formats.",
			words_sent, outputs_seen);
		$display("It saw %0d completed frames and %0d aborted ones; %0d mismatches.",
			frames_seen, aborts_seen, fail_count);
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
